// File: src/point_in_polygon_nearest_vertex_core_defines.svh
// Assertion macros for the point-in-polygon core.
// Needs a clock named clk and an active-low reset named rst_n in the including scope.
`ifndef POINT_IN_POLYGON_NEAREST_VERTEX_CORE_DEFINES_SVH
`define POINT_IN_POLYGON_NEAREST_VERTEX_CORE_DEFINES_SVH

// Consequent holds in the same cycle as the antecedent.
`define PIPNV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define PIPNV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: src/pipnv_pkg.sv
// Package for the point-in-polygon core: sizes, command codes, sequencer states.
// No dependencies.
`timescale 1ns / 1ps

package pipnv_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int ADDR_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int COORD_W      = 16;
  localparam int DIFF_W       = COORD_W + 1;
  localparam int PROD_W       = 2 * DIFF_W;
  localparam int DIST_W       = 33;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD,
    ST_DX,
    ST_DY,
    ST_CMP,
    ST_L,
    ST_R,
    ST_T,
    ST_DONE
  } state_t;

endpackage

// File: src/point_in_polygon_nearest_vertex_core.sv
// Point-in-polygon core with nearest-vertex search: vertex store, sequencer, shared multiplier.
// Depends on pipnv_pkg and point_in_polygon_nearest_vertex_core_defines.svh.
`timescale 1ns / 1ps

// A request is taken when start is high and busy is low. Clear and append leave busy low;
// an append beyond MAX_VERTICES vertices is dropped and sets the overflow flag.
// A query raises busy and walks the stored vertices one at a time through a single 17x17
// signed multiplier under a small sequencer: for every vertex it reads the vertex and squares
// the x and y distances to compare their sum with the best so far; for each further vertex it
// adds two cross products for the edge to the previous vertex, and it ends with the two for
// the closing edge. out_valid then pulses for one cycle (in the cycle after the query is taken
// for an empty polygon), and busy drops in the following cycle. The receiver cannot stall:
// out_valid marks the result for exactly that one cycle; later requests may change the ports.

`include "point_in_polygon_nearest_vertex_core_defines.svh"

module point_in_polygon_nearest_vertex_core
  import pipnv_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  output logic                      busy,
  input  logic [1:0]                in_command,
  input  logic signed [COORD_W-1:0] in_coord_x,
  input  logic signed [COORD_W-1:0] in_coord_y,
  output logic                      out_valid,
  output logic                      out_inside_res,
  output logic signed [COORD_W-1:0] out_nearest_x,
  output logic signed [COORD_W-1:0] out_nearest_y,
  output logic [DIST_W-1:0]         out_nearest_dist_sq,
  output logic                      out_has_vertices,
  output logic                      out_overflowed
);

  logic [COORD_W-1:0] mem_x [MAX_VERTICES];
  logic [COORD_W-1:0] mem_y [MAX_VERTICES];

  state_t state_r, state_nxt;

  logic [CNT_W-1:0]          cnt_r;
  logic [CNT_W-1:0]          idx_r;
  logic                      ovf_r;
  logic                      cls_r;
  logic                      inside_r;
  logic signed [COORD_W-1:0] qx_r, qy_r;
  logic signed [COORD_W-1:0] rd_x_r, rd_y_r;
  logic signed [COORD_W-1:0] prv_x_r, prv_y_r;
  logic signed [COORD_W-1:0] fst_x_r, fst_y_r;
  logic signed [COORD_W-1:0] bx_r, by_r;
  logic [DIST_W-1:0]         best_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic signed [PROD_W-1:0]  acc_r;

  logic                      accept;
  logic                      more;
  logic signed [COORD_W-1:0] e1x, e1y, e2x, e2y;
  logic signed [DIFF_W-1:0]  mul_a, mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic [DIST_W-1:0]         dist_sum;
  logic signed [DIFF_W-1:0]  edge_dy;
  logic                      straddle, prefilter, cross_hit, toggle;

  function automatic logic signed [DIFF_W-1:0] sdiff(logic signed [COORD_W-1:0] a,
                                                     logic signed [COORD_W-1:0] b);
    sdiff = $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
  endfunction

  assign accept = start && !busy;
  assign more   = (idx_r + CNT_W'(1)) < cnt_r;

  // Closing edge runs from the first vertex to the last; otherwise current to previous.
  assign e1x = cls_r ? fst_x_r : rd_x_r;
  assign e1y = cls_r ? fst_y_r : rd_y_r;
  assign e2x = cls_r ? rd_x_r  : prv_x_r;
  assign e2y = cls_r ? rd_y_r  : prv_y_r;

  assign mul_p    = mul_a * mul_b;
  assign dist_sum = {1'b0, acc_r[31:0]} + {1'b0, prod_r[31:0]};
  assign edge_dy  = sdiff(e2y, e1y);

  assign straddle  = (e1y < qy_r && e2y >= qy_r) || (e2y < qy_r && e1y >= qy_r);
  assign prefilter = (e1x <= qx_r) || (e2x <= qx_r);
  // acc holds (qy-y1)*(x2-x1), prod holds (qx-x1)*(y2-y1)
  assign cross_hit = (edge_dy > 0) ? (acc_r < prod_r) : (acc_r > prod_r);
  assign toggle    = straddle && prefilter && cross_hit;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_QUERY) begin
          state_nxt = (cnt_r == '0) ? ST_DONE : ST_RD;
        end
      end
      ST_RD:   state_nxt = ST_DX;
      ST_DX:   state_nxt = ST_DY;
      ST_DY:   state_nxt = ST_CMP;
      ST_CMP: begin
        if (idx_r != '0) begin
          state_nxt = ST_R;
        end else begin
          state_nxt = more ? ST_RD : ST_L;
        end
      end
      ST_L:    state_nxt = ST_R;
      ST_R:    state_nxt = ST_T;
      ST_T: begin
        if (cls_r) begin
          state_nxt = ST_DONE;
        end else begin
          state_nxt = more ? ST_RD : ST_L;
        end
      end
      ST_DONE: state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and multiplier operand selection
  always_comb begin
    busy      = 1'b1;
    out_valid = 1'b0;
    mul_a     = sdiff(qx_r, rd_x_r);
    mul_b     = sdiff(qx_r, rd_x_r);
    case (state_r)
      ST_IDLE: busy = 1'b0;
      ST_DX: begin
        mul_a = sdiff(qx_r, rd_x_r);
        mul_b = sdiff(qx_r, rd_x_r);
      end
      ST_DY: begin
        mul_a = sdiff(qy_r, rd_y_r);
        mul_b = sdiff(qy_r, rd_y_r);
      end
      ST_CMP, ST_L: begin
        mul_a = sdiff(qy_r, e1y);
        mul_b = sdiff(e2x, e1x);
      end
      ST_R: begin
        mul_a = sdiff(qx_r, e1x);
        mul_b = edge_dy;
      end
      ST_DONE: out_valid = 1'b1;
      default: begin
        mul_a = sdiff(qx_r, rd_x_r);
        mul_b = sdiff(qx_r, rd_x_r);
      end
    endcase
  end

  // Vertex store
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && accept && in_command == CMD_APPEND
        && cnt_r < CNT_W'(MAX_VERTICES)) begin
      mem_x[cnt_r[ADDR_W-1:0]] <= in_coord_x;
      mem_y[cnt_r[ADDR_W-1:0]] <= in_coord_y;
    end
    if (state_r == ST_RD) begin
      rd_x_r <= mem_x[idx_r[ADDR_W-1:0]];
      rd_y_r <= mem_y[idx_r[ADDR_W-1:0]];
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      ovf_r   <= 1'b0;
      idx_r   <= '0;
      cls_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (in_command)
              CMD_CLEAR: begin
                cnt_r <= '0;
                ovf_r <= 1'b0;
              end
              CMD_APPEND: begin
                if (cnt_r < CNT_W'(MAX_VERTICES)) begin
                  cnt_r <= cnt_r + CNT_W'(1);
                end else begin
                  ovf_r <= 1'b1;
                end
              end
              CMD_QUERY: begin
                idx_r <= '0;
                cls_r <= 1'b0;
              end
              default: ;
            endcase
          end
        end
        ST_CMP: begin
          if (idx_r == '0) begin
            if (more) idx_r <= idx_r + CNT_W'(1);
            else      cls_r <= 1'b1;
          end
        end
        ST_T: begin
          if (!cls_r) begin
            if (more) idx_r <= idx_r + CNT_W'(1);
            else      cls_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    case (state_r)
      ST_IDLE: begin
        if (accept && in_command == CMD_QUERY) begin
          qx_r     <= in_coord_x;
          qy_r     <= in_coord_y;
          inside_r <= 1'b0;
          best_r   <= '0;
          bx_r     <= '0;
          by_r     <= '0;
        end
      end
      ST_RD: begin
        prv_x_r <= rd_x_r;
        prv_y_r <= rd_y_r;
      end
      ST_DY: acc_r <= prod_r;
      ST_CMP: begin
        if (idx_r == '0 || dist_sum < best_r) begin
          best_r <= dist_sum;
          bx_r   <= rd_x_r;
          by_r   <= rd_y_r;
        end
        if (idx_r == '0) begin
          fst_x_r <= rd_x_r;
          fst_y_r <= rd_y_r;
        end
      end
      ST_R: acc_r <= prod_r;
      ST_T: begin
        if (toggle) inside_r <= !inside_r;
      end
      default: ;
    endcase
  end

  assign out_inside_res      = inside_r;
  assign out_nearest_x       = bx_r;
  assign out_nearest_y       = by_r;
  assign out_nearest_dist_sq = best_r;
  assign out_has_vertices    = (cnt_r != '0);
  assign out_overflowed      = ovf_r;

  `PIPNV_ASSERT_NEXT(a_query_goes_busy, accept && in_command == CMD_QUERY, busy, "query not taken")
  `PIPNV_ASSERT_NEXT(a_single_strobe, out_valid, !out_valid && !busy, "result strobe too long")
  `PIPNV_ASSERT_NOW(a_idx_in_range, busy && cnt_r != '0, idx_r < cnt_r, "vertex index out of range")
  `PIPNV_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_r <= CNT_W'(MAX_VERTICES), "vertex count too large")
  `PIPNV_ASSERT_NEXT(a_cnt_held, busy, $stable(cnt_r) && $stable(ovf_r), "store changed in query")

endmodule

// File: tb/sv/point_in_polygon_nearest_vertex_core_test.sv
// Self-checking testbench for point_in_polygon_nearest_vertex_core: a directed table, then
// random polygons built vertex by vertex and queried, checked against a behavioural predictor.
// Depends on pipnv_pkg and the core itself.
`timescale 1ns / 1ps

module point_in_polygon_nearest_vertex_core_test;
  import pipnv_pkg::*;

  localparam logic [1:0]                CMD_UNUSED = 2'd3;
  localparam logic signed [COORD_W-1:0] COORD_MIN  = 16'sh8000;
  localparam logic signed [COORD_W-1:0] COORD_MAX  = 16'sh7fff;

  typedef struct packed {
    logic                      in_poly;
    logic signed [COORD_W-1:0] near_x;
    logic signed [COORD_W-1:0] near_y;
    logic [DIST_W-1:0]         dist_sq;
    logic                      has_vertices;
    logic                      overflowed;
  } answer_t;

  typedef struct packed {
    logic [1:0]                command;
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic                      typed_in;
    answer_t                   answer;
  } request_row_t;

  localparam answer_t EMPTY_ANSWER  = '0;
  // single vertex at the far corner, query at the opposite corner
  localparam answer_t CORNER_ANSWER = '{1'b0, COORD_MIN, COORD_MIN, 33'd8589672450, 1'b1, 1'b0};
  // centre of the 10x10 square: inside, all four corners tie, first one wins
  localparam answer_t SQUARE_ANSWER = '{1'b1, 16'sd0, 16'sd0, 33'd50, 1'b1, 1'b0};

  localparam request_row_t DIRECTED_ROWS [25] = '{
    '{CMD_QUERY,  16'sd0,    16'sd0,    1'b1, EMPTY_ANSWER},
    '{CMD_UNUSED, COORD_MIN, COORD_MAX, 1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  COORD_MIN, COORD_MIN, 1'b1, EMPTY_ANSWER},
    '{CMD_APPEND, COORD_MIN, COORD_MIN, 1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  COORD_MAX, COORD_MAX, 1'b1, CORNER_ANSWER},
    '{CMD_APPEND, COORD_MAX, COORD_MAX, 1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  16'sd0,    16'sd0,    1'b0, EMPTY_ANSWER},
    '{CMD_CLEAR,  16'sd0,    16'sd0,    1'b0, EMPTY_ANSWER},
    '{CMD_APPEND, 16'sd0,    16'sd0,    1'b0, EMPTY_ANSWER},
    '{CMD_APPEND, 16'sd10,   16'sd0,    1'b0, EMPTY_ANSWER},
    '{CMD_APPEND, 16'sd10,   16'sd10,   1'b0, EMPTY_ANSWER},
    '{CMD_APPEND, 16'sd0,    16'sd10,   1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  16'sd5,    16'sd5,    1'b1, SQUARE_ANSWER},
    '{CMD_QUERY,  16'sd0,    16'sd10,   1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  16'sd10,   16'sd5,    1'b0, EMPTY_ANSWER},
    '{CMD_UNUSED, 16'sd5,    16'sd5,    1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  -16'sd1,   16'sd5,    1'b0, EMPTY_ANSWER},
    '{CMD_CLEAR,  COORD_MAX, COORD_MIN, 1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  16'sd1,    16'sd1,    1'b1, EMPTY_ANSWER},
    '{CMD_APPEND, COORD_MIN, COORD_MIN, 1'b0, EMPTY_ANSWER},
    '{CMD_APPEND, COORD_MAX, COORD_MIN, 1'b0, EMPTY_ANSWER},
    '{CMD_APPEND, 16'sd0,    COORD_MAX, 1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  16'sd0,    16'sd0,    1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  COORD_MIN, COORD_MAX, 1'b0, EMPTY_ANSWER},
    '{CMD_QUERY,  COORD_MAX, -16'sd1,   1'b0, EMPTY_ANSWER}
  };

  logic                      clk;
  logic                      rst_n;
  logic                      start;
  logic                      busy;
  logic [1:0]                in_command;
  logic signed [COORD_W-1:0] in_coord_x;
  logic signed [COORD_W-1:0] in_coord_y;
  logic                      out_valid;
  logic                      out_inside_res;
  logic signed [COORD_W-1:0] out_nearest_x;
  logic signed [COORD_W-1:0] out_nearest_y;
  logic [DIST_W-1:0]         out_nearest_dist_sq;
  logic                      out_has_vertices;
  logic                      out_overflowed;

  // typed-in answer travelling alongside the request
  logic    req_typed_in;
  answer_t req_answer;

  // predictor copy of the polygon
  logic signed [COORD_W-1:0] poly_x [MAX_VERTICES];
  logic signed [COORD_W-1:0] poly_y [MAX_VERTICES];
  int                        poly_count    = 0;
  bit                        poly_overflow = 1'b0;

  answer_t pending_answers [$];
  int      mismatch_count  = 0;
  int      requests_sent   = 0;
  int      sender_idle_pct = 0;

  point_in_polygon_nearest_vertex_core dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .start               (start),
    .busy                (busy),
    .in_command          (in_command),
    .in_coord_x          (in_coord_x),
    .in_coord_y          (in_coord_y),
    .out_valid           (out_valid),
    .out_inside_res      (out_inside_res),
    .out_nearest_x       (out_nearest_x),
    .out_nearest_y       (out_nearest_y),
    .out_nearest_dist_sq (out_nearest_dist_sq),
    .out_has_vertices    (out_has_vertices),
    .out_overflowed      (out_overflowed)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // slowest legal run is about 1850 full-polygon queries; allow several times that
  initial begin
    #200_000_000;
    $display("point_in_polygon_nearest_vertex_core_test failed");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    $display("[%0t] MISMATCH %s", $realtime, msg);
    mismatch_count++;
  endtask

  // Even-odd test for one edge against a ray running towards negative x.
  function automatic bit crosses_ray(input longint x1, input longint y1, input longint x2,
                                     input longint y2, input longint x, input longint y);
    longint dy, lhs, rhs;
    if (!((y1 < y && y2 >= y) || (y2 < y && y1 >= y))) return 1'b0;
    if (!(x1 <= x || x2 <= x)) return 1'b0;
    // exact form of x1 + (y-y1)*(x2-x1)/(y2-y1) < x
    dy  = y2 - y1;
    lhs = (y - y1) * (x2 - x1);
    rhs = (x - x1) * dy;
    return (dy > 0) ? (lhs < rhs) : (lhs > rhs);
  endfunction

  function automatic answer_t locate_point(input logic signed [COORD_W-1:0] qx,
                                           input logic signed [COORD_W-1:0] qy);
    answer_t a;
    longint  px, py, ax, ay, d, best;
    int      prev;
    a    = '0;
    best = 0;
    px   = qx;
    py   = qy;
    for (int i = 0; i < poly_count; i++) begin
      prev = (i == 0) ? poly_count - 1 : i - 1;
      ax   = poly_x[i];
      ay   = poly_y[i];
      if (crosses_ray(ax, ay, poly_x[prev], poly_y[prev], px, py)) a.in_poly = ~a.in_poly;
      d = (px - ax) * (px - ax) + (py - ay) * (py - ay);
      if (i == 0 || d < best) begin
        best     = d;
        a.near_x = poly_x[i];
        a.near_y = poly_y[i];
      end
    end
    a.dist_sq      = best[DIST_W-1:0];
    a.has_vertices = (poly_count > 0);
    a.overflowed   = poly_overflow;
    return a;
  endfunction

  // Check results and track accepted requests, both on the rising edge.
  always @(posedge clk) begin
    answer_t want;
    answer_t queued;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_answers.size() == 0) begin
          report_mismatch("result with no query pending");
        end else begin
          want = pending_answers.pop_front();
          if (out_inside_res !== want.in_poly)
            report_mismatch($sformatf("inside got %b want %b", out_inside_res, want.in_poly));
          if (out_nearest_x !== want.near_x)
            report_mismatch($sformatf("nearest_x got %0d want %0d", out_nearest_x, want.near_x));
          if (out_nearest_y !== want.near_y)
            report_mismatch($sformatf("nearest_y got %0d want %0d", out_nearest_y, want.near_y));
          if (out_nearest_dist_sq !== want.dist_sq)
            report_mismatch($sformatf("dist_sq got %0d want %0d", out_nearest_dist_sq,
                                      want.dist_sq));
          if (out_has_vertices !== want.has_vertices)
            report_mismatch($sformatf("has_vertices got %b want %b", out_has_vertices,
                                      want.has_vertices));
          if (out_overflowed !== want.overflowed)
            report_mismatch($sformatf("overflowed got %b want %b", out_overflowed,
                                      want.overflowed));
        end
      end
      if (start && !busy) begin
        case (in_command)
          CMD_CLEAR: begin
            poly_count    = 0;
            poly_overflow = 1'b0;
          end
          CMD_APPEND: begin
            if (poly_count < MAX_VERTICES) begin
              poly_x[poly_count] = in_coord_x;
              poly_y[poly_count] = in_coord_y;
              poly_count++;
            end else begin
              poly_overflow = 1'b1;
            end
          end
          CMD_QUERY: begin
            queued          = req_typed_in ? req_answer : locate_point(in_coord_x, in_coord_y);
            pending_answers = {pending_answers, queued};
          end
          default: ;
        endcase
      end
    end
  end

  task automatic send_request(input logic [1:0] cmd, input logic signed [COORD_W-1:0] x,
                              input logic signed [COORD_W-1:0] y, input bit typed_in,
                              input answer_t answer);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      @(negedge clk);
      start      <= 1'b0;
      in_command <= 2'($urandom_range(0, 3));
      in_coord_x <= COORD_W'($urandom);
      in_coord_y <= COORD_W'($urandom);
    end
    @(negedge clk);
    start        <= 1'b1;
    in_command   <= cmd;
    in_coord_x   <= x;
    in_coord_y   <= y;
    req_typed_in <= typed_in;
    req_answer   <= answer;
    // busy only moves on the rising edge, so its value here is what that edge sees
    while (busy) @(negedge clk);
    @(posedge clk);
    if (cmd != CMD_UNUSED) requests_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (pending_answers.size() != 0) @(negedge clk);
  endtask

  function automatic logic signed [COORD_W-1:0] pick_coord(input int span);
    case ($urandom_range(0, 19))
      0:       return COORD_MIN;
      1:       return COORD_MAX;
      default: return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  task automatic run_random_phase(input int idle_pct, input int quota);
    int                        sent_at_entry, n_vertices, n_queries, span, pick, v;
    bit                        first;
    logic signed [COORD_W-1:0] qx, qy;
    sender_idle_pct = idle_pct;
    sent_at_entry   = requests_sent;
    first           = 1'b1;
    while (requests_sent - sent_at_entry < quota) begin
      if (!first && $urandom_range(0, 99) < 8) begin
        // noise: any command code, any coordinates
        repeat ($urandom_range(1, 6))
          send_request(2'($urandom_range(0, 3)), COORD_W'($urandom), COORD_W'($urandom),
                       1'b0, '0);
      end else begin
        if (first || $urandom_range(0, 99) < 95)
          send_request(CMD_CLEAR, COORD_W'($urandom), COORD_W'($urandom), 1'b0, '0);
        pick = $urandom_range(0, 99);
        if (first || pick < 2) n_vertices = MAX_VERTICES - 2 + $urandom_range(0, 6);
        else if (pick < 8)     n_vertices = $urandom_range(0, 2);
        else                   n_vertices = $urandom_range(3, 12);
        case ($urandom_range(0, 2))
          0:       span = 20;
          1:       span = 1000;
          default: span = 32767;
        endcase
        for (int k = 0; k < n_vertices; k++) begin
          // now and then a query on a half-built polygon
          if ($urandom_range(0, 19) == 0)
            send_request(CMD_QUERY, pick_coord(span), pick_coord(span), 1'b0, '0);
          send_request(CMD_APPEND, pick_coord(span), pick_coord(span), 1'b0, '0);
        end
        n_queries = (n_vertices > 20) ? 2 : $urandom_range(1, 6);
        repeat (n_queries) begin
          qx = pick_coord(span);
          qy = pick_coord(span);
          // share a vertex's y so the ray runs through vertices
          if (poly_count > 0 && $urandom_range(0, 3) == 0) begin
            v  = $urandom_range(0, poly_count - 1);
            qy = poly_y[v];
            if ($urandom_range(0, 1) == 1) qx = poly_x[v];
          end
          send_request(CMD_QUERY, qx, qy, 1'b0, '0);
        end
      end
      if ($urandom_range(0, 99) < 3) wait_drained();
      first = 1'b0;
    end
    wait_drained();
  endtask

  initial begin
    int drain_cycles;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_command   = CMD_CLEAR;
    in_coord_x   = '0;
    in_coord_y   = '0;
    req_typed_in = 1'b0;
    req_answer   = '0;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    sender_idle_pct = 33;
    for (int r = 0; r < $size(DIRECTED_ROWS); r++)
      send_request(DIRECTED_ROWS[r].command, DIRECTED_ROWS[r].x, DIRECTED_ROWS[r].y,
                   DIRECTED_ROWS[r].typed_in, DIRECTED_ROWS[r].answer);
    wait_drained();

    run_random_phase(33, 608);
    run_random_phase(68, 608);
    run_random_phase(0, 608);

    @(negedge clk);
    start        <= 1'b0;
    drain_cycles = 0;
    while (pending_answers.size() != 0 && drain_cycles < 8 * MAX_VERTICES * 6) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (16) @(negedge clk);
    if (pending_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_answers.size()));
    if (mismatch_count == 0) begin
      $display("point_in_polygon_nearest_vertex_core_test passed");
    end else begin
      $display("point_in_polygon_nearest_vertex_core_test failed");
    end
    $finish;
  end

endmodule

// File: point_in_polygon_nearest_vertex_core.f
+incdir+src
src/pipnv_pkg.sv
src/point_in_polygon_nearest_vertex_core.sv
tb/sv/point_in_polygon_nearest_vertex_core_test.sv
